FILE: hdl/dwhr_pkg.sv
// dwhr_pkg: operation, status and controller state types for the deque
// with half rotation. No dependencies.
package dwhr_pkg;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_POP_FRONT  = 3'd1,
      OP_PUSH_BACK  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_SWAP       = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      S_IDLE,
      S_READ
   } state_type;

   // swap halves needs at least this many elements to move the front
   localparam int MIN_SWAP_COUNT = 2;

endpackage

FILE: hdl/dwhr_req_if.sv
// dwhr_req_if: request channel (opcode and push word) with valid/ready.
// No dependencies.
interface dwhr_req_if #(
   parameter int WORD_BITS = 32
);
   logic                 valid;
   logic                 ready;
   logic [2:0]           opcode;
   logic [WORD_BITS-1:0] push_value;

   modport source (output valid, output opcode, output push_value, input ready);
   modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

FILE: hdl/dwhr_rsp_if.sv
// dwhr_rsp_if: response channel (popped word, status, occupancy) with
// valid/ready. No dependencies.
interface dwhr_rsp_if #(
   parameter int WORD_BITS = 32,
   parameter int OCC_BITS  = 11
);
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] pop_value;
   logic [1:0]           status;
   logic [OCC_BITS-1:0]  occupancy;

   modport source (output valid, output pop_value, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input pop_value, input status, input occupancy,
                   output ready);
endinterface

FILE: hdl/deque_with_half_rotation.sv
// deque_with_half_rotation: double-ended queue in a circular single-port
// store with front pointer and count. Uses dwhr_pkg, dwhr_req_if, dwhr_rsp_if.
//
//   channel   | modport | payload
//   ----------+---------+-------------------------------------
//   req_chan  | sink    | opcode, push_value
//   rsp_chan  | source  | pop_value, status, occupancy
//
// pushes, swaps, failed and unused ops answer in the cycle after acceptance;
// pops pass through the registered read of the element store, then the output register.
// one word is in flight at a time; a new request is taken in the cycle the
// previous response leaves the output register.
// reset (synchronous) clears pointer, count and handshake state; the store
// itself is not cleared. a stalled response holds in the output register.
module deque_with_half_rotation #(
   parameter int CAPACITY  = 1024,
   parameter int WORD_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   dwhr_req_if.sink   req_chan,
   dwhr_rsp_if.source rsp_chan
);
   import dwhr_pkg::*;

   localparam int IDX_BITS = $clog2(CAPACITY);
   localparam int CNT_BITS = $clog2(CAPACITY + 1);
   localparam int SUM_BITS = IDX_BITS + 1;

   // element store
   logic [WORD_BITS-1:0] mem [CAPACITY];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 mem_we;
   logic                 mem_re;
   logic [IDX_BITS-1:0]  mem_addr;

   state_type state_ff, state_in;
   logic [IDX_BITS-1:0]  front_ff, front_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;

   logic                 out_valid_ff, out_valid_in;
   logic [WORD_BITS-1:0] out_value_ff, out_value_in;
   status_type           out_status_ff, out_status_in;
   logic [CNT_BITS-1:0]  out_occ_ff, out_occ_in;

   logic                 accept;
   logic                 go_read;
   logic                 is_full;
   logic                 is_empty;
   logic [IDX_BITS-1:0]  front_dec;
   logic [IDX_BITS-1:0]  front_inc;
   logic [IDX_BITS-1:0]  back_slot;
   logic [IDX_BITS-1:0]  last_slot;
   logic [IDX_BITS-1:0]  half_slot;

   // sum is below twice the capacity, so one compare and subtract wraps it
   function automatic logic [IDX_BITS-1:0] wrap_sum(input logic [SUM_BITS-1:0] s);
      logic [SUM_BITS-1:0] t;
      begin
         t = s;
         if (s >= SUM_BITS'(CAPACITY)) begin
            t = s - SUM_BITS'(CAPACITY);
         end
         return t[IDX_BITS-1:0];
      end
   endfunction

   assign req_chan.ready = (state_ff == S_IDLE) && (!out_valid_ff || rsp_chan.ready);
   assign accept   = req_chan.valid && req_chan.ready;
   assign is_full  = (count_ff == CNT_BITS'(CAPACITY));
   assign is_empty = (count_ff == '0);

   assign front_dec = (front_ff == '0) ? IDX_BITS'(CAPACITY - 1) : front_ff - 1'b1;
   assign front_inc = (front_ff == IDX_BITS'(CAPACITY - 1)) ? '0 : front_ff + 1'b1;
   assign back_slot = wrap_sum(SUM_BITS'(front_ff) + SUM_BITS'(count_ff));
   assign last_slot = wrap_sum(SUM_BITS'(front_ff) + SUM_BITS'(count_ff) - 1'b1);
   assign half_slot = wrap_sum(SUM_BITS'(front_ff) + SUM_BITS'(count_ff >> 1));

   // operation decode and pointer arithmetic
   always_comb begin
      front_in      = front_ff;
      count_in      = count_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_addr      = front_ff;
      go_read       = 1'b0;
      out_status_in = STAT_OK;
      if (accept) begin
         case (req_chan.opcode)
            OP_PUSH_FRONT: begin
               if (is_full) begin
                  out_status_in = STAT_FULL;
               end else begin
                  mem_we   = 1'b1;
                  mem_addr = front_dec;
                  front_in = front_dec;
                  count_in = count_ff + 1'b1;
               end
            end
            OP_POP_FRONT: begin
               if (is_empty) begin
                  out_status_in = STAT_EMPTY;
               end else begin
                  mem_re   = 1'b1;
                  go_read  = 1'b1;
                  mem_addr = front_ff;
                  front_in = front_inc;
                  count_in = count_ff - 1'b1;
               end
            end
            OP_PUSH_BACK: begin
               if (is_full) begin
                  out_status_in = STAT_FULL;
               end else begin
                  mem_we   = 1'b1;
                  mem_addr = back_slot;
                  count_in = count_ff + 1'b1;
               end
            end
            OP_POP_BACK: begin
               if (is_empty) begin
                  out_status_in = STAT_EMPTY;
               end else begin
                  mem_re   = 1'b1;
                  go_read  = 1'b1;
                  mem_addr = last_slot;
                  count_in = count_ff - 1'b1;
               end
            end
            OP_SWAP: begin
               if (count_ff >= CNT_BITS'(MIN_SWAP_COUNT)) begin
                  front_in = half_slot;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (go_read) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // handshake and response register
   always_comb begin
      out_valid_in   = out_valid_ff && !rsp_chan.ready;
      out_value_in   = out_value_ff;
      out_occ_in     = out_occ_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // pops wait for the registered store read, the rest answer at once
               out_valid_in = !go_read;
               out_value_in = '0;
               out_occ_in   = count_in;
            end
         end
         S_READ: begin
            out_valid_in = 1'b1;
            out_value_in = rd_data_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= req_chan.push_value;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff <= out_value_in;
      out_occ_ff   <= out_occ_in;
      if (accept) begin
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.pop_value = out_value_ff;
   assign rsp_chan.status    = out_status_ff;
   assign rsp_chan.occupancy = out_occ_ff;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for deque_with_half_rotation, driving words
// through dwhr_req_if and checking every response word from dwhr_rsp_if
// against an in-bench deque model. Depends on dwhr_pkg and the two interfaces.
module testbench;
   import dwhr_pkg::*;

   localparam int DEPTH       = 1024;
   localparam int WORD_W      = 32;
   localparam int OCC_W       = 11;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int PERIOD      = 10;
   localparam int RESET_LEN   = 6;
   localparam int IDLE_PCT    = 16;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 20;
   localparam int QUIET_WORDS = 400;
   localparam int TIMEOUT_NS  = 2_000_000;

   // opcodes the block leaves unused
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

   localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
   localparam logic [WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;
   localparam logic [WORD_W-1:0] WORD_ONES = 32'hffff_ffff;

   typedef struct packed {
      logic [WORD_W-1:0] pop_value;
      status_type        status;
      logic [OCC_W-1:0]  occupancy;
   } deque_result_type;

   logic clock = 1'b0;
   logic reset;

   dwhr_req_if #(.WORD_BITS(WORD_W)) req_bus ();
   dwhr_rsp_if #(.WORD_BITS(WORD_W), .OCC_BITS(OCC_W)) rsp_bus ();

   deque_with_half_rotation #(
      .CAPACITY  (DEPTH),
      .WORD_BITS (WORD_W)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #(PERIOD / 2) clock = ~clock;

   // shadow deque
   logic [WORD_W-1:0] ring_store [DEPTH];
   logic [IDX_W-1:0]  head;
   logic [OCC_W-1:0]  level;

   deque_result_type pending_results [$];
   int               faults;
   bit               quiet;
   bit               hold_request;

   function automatic deque_result_type apply_op(input logic [2:0] op,
                                                 input logic [WORD_W-1:0] word);
      deque_result_type outcome;
      logic [IDX_W-1:0] slot;
      outcome.pop_value = '0;
      outcome.status    = STAT_OK;
      case (op)
         OP_PUSH_FRONT: begin
            if (level == DEPTH) begin
               outcome.status = STAT_FULL;
            end else begin
               head             = head - 1'b1;
               ring_store[head] = word;
               level            = level + 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (level == 0) begin
               outcome.status = STAT_EMPTY;
            end else begin
               outcome.pop_value = ring_store[head];
               head              = head + 1'b1;
               level             = level - 1'b1;
            end
         end
         OP_PUSH_BACK: begin
            if (level == DEPTH) begin
               outcome.status = STAT_FULL;
            end else begin
               slot             = IDX_W'(head + level);
               ring_store[slot] = word;
               level            = level + 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (level == 0) begin
               outcome.status = STAT_EMPTY;
            end else begin
               slot              = IDX_W'(head + level - 1'b1);
               outcome.pop_value = ring_store[slot];
               level             = level - 1'b1;
            end
         end
         OP_SWAP: begin
            // front moves to the middle element, nothing is copied
            if (level >= MIN_SWAP_COUNT) head = IDX_W'(head + level / 2);
         end
         default: begin
         end
      endcase
      outcome.occupancy = level;
      return outcome;
   endfunction

   function automatic logic [2:0] pick_op(input int push_pct);
      int r;
      r = $urandom_range(99);
      if (r < push_pct) return $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      if (r < 95) return $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
      if (r < 99) return OP_SWAP;
      return 3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
   endfunction

   // valid stays high after acceptance so the next word can follow at once
   task automatic offer_word(input logic [2:0] op, input logic [WORD_W-1:0] word);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.opcode     <= op;
      req_bus.push_value <= word;
      do @(posedge clock); while (!req_bus.ready);
      pending_results.push_back(apply_op(op, word));
   endtask

   task automatic random_ops(input int count, input int push_pct);
      repeat (count) offer_word(pick_op(push_pct), $urandom);
   endtask

   task automatic test_empty_queue();
      offer_word(OP_POP_FRONT, $urandom);
      offer_word(OP_POP_BACK, $urandom);
      offer_word(OP_SWAP, $urandom);
      for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) begin
         offer_word(3'(op), $urandom);
      end
   endtask

   task automatic test_field_extremes();
      offer_word(OP_PUSH_BACK, WORD_MIN);
      offer_word(OP_SWAP, $urandom);          // single element, no move
      offer_word(OP_PUSH_FRONT, WORD_MAX);
      offer_word(OP_SWAP, $urandom);
      offer_word(OP_PUSH_BACK, WORD_ONES);
      offer_word(OP_SWAP, $urandom);          // odd count
      offer_word(OP_PUSH_FRONT, '0);
      offer_word(OP_SWAP, $urandom);
      offer_word(OP_SPARE_LAST, $urandom);    // unused code with data held
      offer_word(OP_POP_FRONT, $urandom);
      offer_word(OP_POP_BACK, $urandom);
      offer_word(OP_POP_FRONT, $urandom);
      offer_word(OP_POP_BACK, $urandom);
      offer_word(OP_POP_BACK, $urandom);
   endtask

   task automatic test_shuffle_low();
      random_ops(300, 50);
   endtask

   task automatic test_output_hold();
      hold_request = 1'b1;
      random_ops(40, 60);
   endtask

   task automatic test_fill_to_capacity();
      int issued;
      issued = 0;
      while (level < DEPTH) begin
         quiet = (issued < QUIET_WORDS);
         offer_word(pick_op(90), $urandom);
         issued++;
      end
      quiet = 1'b0;
      // pushes against a full store, with the odd pop reopening a slot
      random_ops(40, 90);
   endtask

   task automatic test_mixed_near_full();
      random_ops(350, 45);
   endtask

   initial begin : response_sink
      deque_result_type want;
      int               hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_results.size() == 0) begin
               $error("response word with nothing outstanding");
               faults++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_bus.pop_value !== want.pop_value) begin
                  $error("pop_value: expected %0d, got %0d",
                         $signed(want.pop_value), $signed(rsp_bus.pop_value));
                  faults++;
               end
               if (rsp_bus.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
                  faults++;
               end
               if (rsp_bus.occupancy !== want.occupancy) begin
                  $error("occupancy: expected %0d, got %0d",
                         want.occupancy, rsp_bus.occupancy);
                  faults++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
         end else if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         rsp_bus.ready <= (hold_left == 0) && (quiet || $urandom_range(99) >= IDLE_PCT);
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("deque_with_half_rotation: mismatch");
      $finish;
   end

   initial begin
      faults       = 0;
      quiet        = 1'b0;
      hold_request = 1'b0;
      head         = '0;
      level        = '0;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.opcode     <= OP_PUSH_FRONT;
      req_bus.push_value <= '0;
      repeat (RESET_LEN) @(posedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_field_extremes();
      test_shuffle_low();
      test_output_hold();
      test_fill_to_capacity();
      test_mixed_near_full();

      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (faults == 0) begin
         $display("deque_with_half_rotation: match");
      end else begin
         $display("deque_with_half_rotation: mismatch");
      end
      $finish;
   end

endmodule
